FILE: src/stack_with_search_replace_assert.svh
// Assertion macros shared by the stack checker.
// Depends on nothing; include once through the guard below.
`ifndef STACK_WITH_SEARCH_REPLACE_ASSERT_SVH
`define STACK_WITH_SEARCH_REPLACE_ASSERT_SVH

// Same-cycle implication, clocked and disabled in reset.
`define SWSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked and disabled in reset.
`define SWSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/swsr_pkg.sv
// Shared types and constants for the search-and-replace stack.
// Used by the cell, the top level and the checker.
package swsr_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 7;

    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_REPLACE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [WORD_W-1:0] data_value;
        logic signed [WORD_W-1:0] match_value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] top_value;
        logic                     top_valid;
        logic [COUNT_W-1:0]       entry_count;
    } t_result;

    typedef struct packed {
        logic                     shift_dn;
        logic                     shift_up;
        logic                     step;
        logic                     tok_in;
        logic                     write_en;
        logic signed [WORD_W-1:0] wdata;
    } t_cell_ctl;

endpackage

FILE: src/swsr_cell.sv
// One stack slot: holds a word, shifts with its neighbors on push and pop,
// and passes the search token down the row. Depends on swsr_pkg.
module swsr_cell
    import swsr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic signed [WORD_W-1:0] i_key,
    input  logic signed [WORD_W-1:0] i_up_data,
    input  logic signed [WORD_W-1:0] i_dn_data,
    input  logic                     i_tok,
    output logic signed [WORD_W-1:0] o_data,
    output logic                     o_tok,
    output logic                     o_hit
);

    logic signed [WORD_W-1:0] r_data;
    logic                     r_tok;

    assign o_hit  = r_tok && (r_data == i_key);
    assign o_data = r_data;
    assign o_tok  = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_ctl.step ? i_tok : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_dn) begin
            r_data <= i_up_data;
        end else if (i_ctl.shift_up) begin
            r_data <= i_dn_data;
        end else if (i_ctl.write_en && o_hit) begin
            r_data <= i_ctl.wdata;
        end
    end

endmodule

FILE: src/stack_with_search_replace.sv
// Top level of the search-and-replace stack: a row of slot cells, top at
// cell 0, and the command sequencer. Depends on swsr_pkg and swsr_cell.
//
// Usage:
//   A command beat is taken at a rising edge with start high and busy low.
//   Each command gives exactly one result beat on o_result, marked by
//   o_strobe for one cycle; the receiver cannot hold it off.
//   Push, pop and unused codes: result strobe the cycle after the command,
//   so a new command can follow every cycle.
//   Replace: a search token enters the top cell and walks down one cell per
//   cycle; it stops at the first equal entry or at the bottom entry. Busy is
//   high while the token walks; the result strobe is registered when it stops.
//   Replace on an empty stack answers the cycle after the command.
//   Result fields show the stack after the command; top_value is zero when
//   the stack is empty.
//   Reset empties the stack and clears any search in flight; slot contents
//   are not cleared and are never shown before they are written.
module stack_with_search_replace
    import swsr_pkg::*;
#(
    parameter int STACK_DEPTH = DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_idx, n_idx;
    logic signed [WORD_W-1:0] r_key, n_key;
    logic signed [WORD_W-1:0] r_wdata, n_wdata;
    logic [1:0]               r_status, n_status;
    logic                     r_strobe, n_strobe;

    t_cell_ctl                w_ctl;
    logic signed [WORD_W-1:0] w_data [STACK_DEPTH];
    logic                     w_tok  [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]   w_hit;
    logic                     w_any_hit;
    logic                     w_accept;

    assign w_accept  = start && (r_state == S_IDLE);
    assign w_any_hit = |w_hit;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic signed [WORD_W-1:0] w_up;
            logic signed [WORD_W-1:0] w_dn;
            logic                     w_tin;
            if (g == 0) begin : g_top
                assign w_up  = w_ctl.wdata;
                assign w_tin = w_ctl.tok_in;
            end else begin : g_mid
                assign w_up  = w_data[g-1];
                assign w_tin = w_tok[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_bot
                assign w_dn = '0;
            end else begin : g_nb
                assign w_dn = w_data[g+1];
            end
            swsr_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_key     (r_key),
                .i_up_data (w_up),
                .i_dn_data (w_dn),
                .i_tok     (w_tin),
                .o_data    (w_data[g]),
                .o_tok     (w_tok[g]),
                .o_hit     (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_key    = r_key;
        n_wdata  = r_wdata;
        n_status = r_status;
        n_strobe = 1'b0;

        w_ctl          = '0;
        w_ctl.wdata    = (r_state == S_IDLE) ? i_cmd.data_value : r_wdata;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    case (i_cmd.command)
                        CMD_PUSH: begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.shift_dn = 1'b1;
                                n_count        = r_count + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ctl.shift_up = 1'b1;
                                n_count        = r_count - CW'(1);
                            end
                        end
                        CMD_REPLACE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_strobe     = 1'b0;
                                w_ctl.step   = 1'b1;
                                w_ctl.tok_in = 1'b1;
                                n_key        = i_cmd.match_value;
                                n_wdata      = i_cmd.data_value;
                                n_idx        = '0;
                                n_state      = S_SEARCH;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                w_ctl.write_en = 1'b1;
                if (w_any_hit) begin
                    n_status = ST_OK;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (CW'(r_idx) == r_count - CW'(1)) begin
                    n_status = ST_NOT_FOUND;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    w_ctl.step = 1'b1;
                    n_idx      = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_status <= ST_OK;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_status <= n_status;
            r_strobe <= n_strobe;
        end
        r_key   <= n_key;
        r_wdata <= n_wdata;
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_strobe             = r_strobe;
    assign o_result.status      = r_status;
    assign o_result.top_valid   = (r_count != '0);
    assign o_result.top_value   = (r_count != '0) ? w_data[0] : '0;
    assign o_result.entry_count = COUNT_W'(r_count);

endmodule

FILE: src/swsr_checker.sv
// Port-level checker for the search-and-replace stack, bound to the top.
// Depends on swsr_pkg and stack_with_search_replace_assert.svh.
`include "stack_with_search_replace_assert.svh"

module swsr_checker
    import swsr_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    `SWSR_ASSERT_NEXT(a_beat_answered, i_clk, i_rst_n, start && !busy, o_strobe || busy, "command beat neither answered nor searching")
    `SWSR_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result beat while busy")
    `SWSR_ASSERT_SAME(a_search_ends, i_clk, i_rst_n, $fell(busy), o_strobe, "search ended without result beat")
    `SWSR_ASSERT_SAME(a_empty_flag, i_clk, i_rst_n, o_strobe && (o_result.status == ST_EMPTY), !o_result.top_valid, "pop on empty shows a valid top")
    `SWSR_ASSERT_SAME(a_full_flag, i_clk, i_rst_n, o_strobe && (o_result.status == ST_FULL), o_result.top_valid, "push on full shows no top")

endmodule

bind stack_with_search_replace swsr_checker u_swsr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
